// File: rtl/keypad_integer_calculator_defines.svh
// Assertion macros used by the keypad calculator checker.
`ifndef KEYPAD_INTEGER_CALCULATOR_DEFINES_SVH
`define KEYPAD_INTEGER_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define KIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad calculator: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define KIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad calculator: next-cycle check failed");

`endif

// File: rtl/kic_pkg.sv
// Constants and types of the keypad integer calculator.
`timescale 1ns / 1ps
package kic_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned SHOWN_WIDTH = 64;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH);

  localparam int unsigned IN_DATA_WIDTH  = 8;
  localparam int unsigned OUT_DATA_WIDTH = 72;

  typedef enum logic [1:0] {
    KIND_DIGIT    = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_EQUALS   = 2'd3
  } kind_e;

  // Pending operation: key code plus one, zero when nothing is pending.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_XOR  = 3'd1,
    OP_AND  = 3'd2,
    OP_OR   = 3'd3,
    OP_ADD  = 3'd4,
    OP_SUB  = 3'd5,
    OP_MUL  = 3'd6,
    OP_DIV  = 3'd7
  } op_e;

  // Highest operator key code that means anything.
  localparam logic [2:0] OPC_LAST = 3'd6;

  // Lowest digit value that is only legal in base sixteen.
  localparam logic [3:0] DEC_DIGIT_LIMIT = 4'd10;

endpackage

// File: rtl/keypad_integer_calculator.sv
// Keypad integer calculator: sequencer around one shared add/subtract unit.
`timescale 1ns / 1ps
// Usage
// -----
// The slave stream carries one key press per beat: tuser holds the key kind
// (digit, operator, clear, equals) and tdata the digit and the operator code.
// Every accepted key gives exactly one beat on the master stream: the value
// of the operand now selected for entry, sign-extended to 64 bits, with the
// ignored-key and divide-by-zero flags, and tuser saying whether that value
// is the second operand. The radix register is written through cfg_wr_en_i
// and is meant to change only while no key is in flight.
// A digit in base ten is scaled by ten before it is added. The multiply and
// divide iterate one bit per cycle through the shared adder, so one key is
// worked on at a time and tready is low until the sequencer is back in idle.
// The result waits in an output register, so the next key is taken while the
// receiver stalls; a further result then waits until the earlier one has
// gone. Reset clears both operands, the pending operator and the entry flags,
// and sets the radix to sixteen.
module keypad_integer_calculator
  import kic_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration: radix_hex.
  input  logic                      cfg_wr_en_i,
  input  logic                      cfg_wr_data_i,
  // Key press stream.
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata_i,  // digit[3:0], operator_code[6:4]
  input  logic [1:0]                s_axis_tuser_i,  // kind[1:0]
  // Result stream.
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o,  // shown_value[63:0], key_ignored[64],
                                                     // divide_by_zero[65]
  output logic                      m_axis_tuser_o   // showing_second[0]
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIG_SCALE,
    S_DIG_ADD,
    S_FOLD,
    S_MUL,
    S_DIV_ABS_A,
    S_DIV_ABS_B,
    S_DIV,
    S_DIV_SIGN,
    S_FOLD_END,
    S_RESULT
  } state_e;

  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

  state_e                 state_q;
  logic                   radix_hex_q;
  logic [VALUE_WIDTH-1:0] first_q;
  logic [VALUE_WIDTH-1:0] second_q;
  logic                   entering_q;
  logic                   op_just_q;
  op_e                    pending_q;
  op_e                    fold_op_q;

  // Latched key.
  kind_e                  kind_q;
  logic [3:0]             digit_q;
  logic [2:0]             code_q;

  // Working registers of the shared unit.
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [VALUE_WIDTH-1:0] mq_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] dvs_q;
  logic [CNT_WIDTH-1:0]   cnt_q;
  logic                   neg_q;
  logic                   ignored_q;
  logic                   dz_q;

  // Output register.
  logic                   out_valid_q;
  logic [SHOWN_WIDTH-1:0] out_value_q;
  logic                   out_second_q;
  logic                   out_ignored_q;
  logic                   out_dz_q;

  // Shared adder/subtractor.
  logic [VALUE_WIDTH-1:0] alu_a;
  logic [VALUE_WIDTH-1:0] alu_b;
  logic                   alu_sub;
  logic [VALUE_WIDTH:0]   alu_sum;
  logic [VALUE_WIDTH-1:0] rem_shift;
  logic [VALUE_WIDTH-1:0] shown_raw;

  assign rem_shift = {rem_q[VALUE_WIDTH-2:0], mq_q[VALUE_WIDTH-1]};
  assign shown_raw = entering_q ? second_q : first_q;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_DIG_SCALE: begin
        // x * 10 = x * 8 + x * 2
        alu_a = acc_q << 3;
        alu_b = acc_q << 1;
      end
      S_DIG_ADD: begin
        alu_a = radix_hex_q ? (acc_q << 4) : acc_q;
        alu_b = VALUE_WIDTH'(digit_q);
      end
      S_FOLD: begin
        alu_a   = first_q;
        alu_b   = second_q;
        alu_sub = (fold_op_q == OP_SUB);
      end
      S_MUL: begin
        alu_a = acc_q << 1;
        alu_b = mq_q[VALUE_WIDTH-1] ? first_q : '0;
      end
      S_DIV_ABS_A: begin
        alu_b   = first_q;
        alu_sub = first_q[VALUE_WIDTH-1];
      end
      S_DIV_ABS_B: begin
        alu_b   = second_q;
        alu_sub = second_q[VALUE_WIDTH-1];
      end
      S_DIV: begin
        alu_a   = rem_shift;
        alu_b   = dvs_q;
        alu_sub = 1'b1;
      end
      S_DIV_SIGN: begin
        alu_b   = mq_q;
        alu_sub = neg_q;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // With subtraction the carry out is high when there was no borrow.
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {VALUE_WIDTH{alu_sub}}}
                 + (VALUE_WIDTH + 1)'(alu_sub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_hex_q <= 1'b1;
      first_q     <= '0;
      second_q    <= '0;
      entering_q  <= 1'b0;
      op_just_q   <= 1'b0;
      pending_q   <= OP_NONE;
      fold_op_q   <= OP_NONE;
      kind_q      <= KIND_DIGIT;
      cnt_q       <= '0;
      ignored_q   <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        radix_hex_q <= cfg_wr_data_i;
      end
      // In the result state the output register is reloaded instead.
      if (m_axis_tready_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q    <= kind_e'(s_axis_tuser_i);
            digit_q   <= s_axis_tdata_i[3:0];
            code_q    <= s_axis_tdata_i[6:4];
            ignored_q <= 1'b0;
            dz_q      <= 1'b0;
            state_q   <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          unique case (kind_q)
            KIND_DIGIT: begin
              acc_q <= shown_raw;
              if (!radix_hex_q && (digit_q >= DEC_DIGIT_LIMIT)) begin
                ignored_q <= 1'b1;
                state_q   <= S_RESULT;
              end else if (radix_hex_q) begin
                state_q <= S_DIG_ADD;
              end else begin
                state_q <= S_DIG_SCALE;
              end
            end
            KIND_OPERATOR: begin
              if (code_q > OPC_LAST) begin
                state_q <= S_RESULT;
              end else begin
                pending_q <= op_e'(code_q + 3'd1);
                if (!op_just_q && entering_q) begin
                  fold_op_q <= pending_q;
                  state_q   <= S_FOLD;
                end else begin
                  entering_q <= 1'b1;
                  op_just_q  <= 1'b1;
                  state_q    <= S_RESULT;
                end
              end
            end
            KIND_CLEAR: begin
              first_q    <= '0;
              second_q   <= '0;
              pending_q  <= OP_NONE;
              entering_q <= 1'b0;
              op_just_q  <= 1'b0;
              state_q    <= S_RESULT;
            end
            KIND_EQUALS: begin
              fold_op_q <= pending_q;
              pending_q <= OP_NONE;
              state_q   <= S_FOLD;
            end
            default: begin
              state_q <= S_RESULT;
            end
          endcase
        end

        S_DIG_SCALE: begin
          acc_q   <= alu_sum[VALUE_WIDTH-1:0];
          state_q <= S_DIG_ADD;
        end

        S_DIG_ADD: begin
          if (entering_q) begin
            second_q <= alu_sum[VALUE_WIDTH-1:0];
          end else begin
            first_q <= alu_sum[VALUE_WIDTH-1:0];
          end
          op_just_q <= 1'b0;
          state_q   <= S_RESULT;
        end

        S_FOLD: begin
          state_q <= S_FOLD_END;
          unique case (fold_op_q)
            OP_NONE: ;
            OP_XOR:  first_q <= first_q ^ second_q;
            OP_AND:  first_q <= first_q & second_q;
            OP_OR:   first_q <= first_q | second_q;
            OP_ADD,
            OP_SUB:  first_q <= alu_sum[VALUE_WIDTH-1:0];
            OP_MUL: begin
              acc_q   <= '0;
              mq_q    <= second_q;
              cnt_q   <= '0;
              state_q <= S_MUL;
            end
            OP_DIV: begin
              if (second_q == '0) begin
                dz_q <= 1'b1;
              end else begin
                state_q <= S_DIV_ABS_A;
              end
            end
            default: ;
          endcase
        end

        // Multiplier bits from the top down: acc = 2 * acc + bit * first.
        S_MUL: begin
          acc_q <= alu_sum[VALUE_WIDTH-1:0];
          mq_q  <= mq_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            first_q <= alu_sum[VALUE_WIDTH-1:0];
            state_q <= S_FOLD_END;
          end
        end

        S_DIV_ABS_A: begin
          mq_q    <= alu_sum[VALUE_WIDTH-1:0];
          neg_q   <= first_q[VALUE_WIDTH-1] ^ second_q[VALUE_WIDTH-1];
          rem_q   <= '0;
          state_q <= S_DIV_ABS_B;
        end

        S_DIV_ABS_B: begin
          dvs_q   <= alu_sum[VALUE_WIDTH-1:0];
          cnt_q   <= '0;
          state_q <= S_DIV;
        end

        // Restoring division; the quotient bits shift into mq from the bottom.
        S_DIV: begin
          rem_q <= alu_sum[VALUE_WIDTH] ? alu_sum[VALUE_WIDTH-1:0] : rem_shift;
          mq_q  <= {mq_q[VALUE_WIDTH-2:0], alu_sum[VALUE_WIDTH]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_DIV_SIGN;
          end
        end

        S_DIV_SIGN: begin
          first_q <= alu_sum[VALUE_WIDTH-1:0];
          state_q <= S_FOLD_END;
        end

        S_FOLD_END: begin
          entering_q <= (kind_q == KIND_EQUALS) ? op_just_q : 1'b1;
          op_just_q  <= 1'b0;
          second_q   <= '0;
          state_q    <= S_RESULT;
        end

        S_RESULT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q   <= 1'b1;
            out_value_q   <= SHOWN_WIDTH'($signed(shown_raw));
            out_second_q  <= entering_q;
            out_ignored_q <= ignored_q;
            out_dz_q      <= dz_q;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_WIDTH - SHOWN_WIDTH - 2)'(0),
                            out_dz_q, out_ignored_q, out_value_q};
  assign m_axis_tuser_o  = out_second_q;

endmodule

// File: rtl/kic_checker.sv
// Port-level checker of the keypad integer calculator, bound to the top level.
`timescale 1ns / 1ps
`include "keypad_integer_calculator_defines.svh"
module kic_checker
  import kic_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o,
  input logic                      m_axis_tuser_o
);

  logic in_beat;
  logic out_stall;
  logic out_dz;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_dz    = m_axis_tvalid_o && m_axis_tdata_o[SHOWN_WIDTH + 1];

  // A stalled result stays offered.
  `KIC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o)

  // A stalled result does not change.
  `KIC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // Once a key is taken the sequencer is busy with it.
  `KIC_ASSERT_NEXT(a_busy_after_key, clk_i, rst_ni, in_beat, !s_axis_tready_o)

  // A divide fold clears the second operand, so showing it shows zero.
  `KIC_ASSERT_SAME(a_dz_second_zero, clk_i, rst_ni, out_dz && m_axis_tuser_o, m_axis_tdata_o[SHOWN_WIDTH-1:0] == '0)

endmodule

bind keypad_integer_calculator kic_checker u_kic_checker (.*);
